// ===== hdl/hslcl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hslcl_pkg;

	localparam int FRAC_BITS = 16;

	localparam int XW = FRAC_BITS + 1;
	localparam int DW = FRAC_BITS + 2;
	localparam int HW = FRAC_BITS + 3;
	localparam int CW = FRAC_BITS + 3;

	localparam int DIV_LAT = FRAC_BITS + 1;
	localparam int LAT = 14 + 2 * DIV_LAT;

	localparam logic [XW-1:0] ONE = XW'(1) << FRAC_BITS;
	localparam logic [XW-1:0] HALF = XW'(1) << (FRAC_BITS - 1);
	localparam logic [DW-1:0] TWO = DW'(1) << (FRAC_BITS + 1);

	localparam longint unsigned K255_L = (64'd1 << (FRAC_BITS + 8)) / 255;
	localparam longint unsigned K100_L = (64'd1 << (FRAC_BITS + 8)) / 100;
	localparam logic [XW-1:0] K255 = XW'(K255_L);
	localparam logic [DW-1:0] K100 = DW'(K100_L);

	localparam logic [2:0] HUE_B1 = 3'd1;
	localparam logic [2:0] HUE_B3 = 3'd3;
	localparam logic [2:0] HUE_B5 = 3'd5;

	localparam logic [2:0] SEC1 = 3'd1;
	localparam logic [2:0] SEC2 = 3'd2;
	localparam logic [2:0] SEC3 = 3'd3;
	localparam logic [2:0] SEC4 = 3'd4;
	localparam logic [2:0] SEC5 = 3'd5;

	localparam logic signed [7:0] LIGHTEN_RST = 8'sd13;

	// estimate of c * ONE / 255, low by at most one
	function automatic logic [XW-1:0] fx_est(input logic [7:0] c);
		logic [XW+7:0] p;
		p = (XW+8)'(c) * (XW+8)'(K255);
		return p[XW+7:8];
	endfunction

	function automatic logic [XW-1:0] fx_fix(input logic [7:0] c, input logic [XW-1:0] q);
		logic [XW+9:0] lhs;
		logic [XW+9:0] qp;
		logic [XW+9:0] rhs;
		lhs = (XW+10)'(c) << FRAC_BITS;
		qp = (XW+10)'(q) + (XW+10)'(1);
		rhs = (qp << 8) - qp;
		return (lhs >= rhs) ? q + XW'(1) : q;
	endfunction

	function automatic logic [DW-1:0] mag_est(input logic [7:0] p);
		logic [DW+9:0] t;
		t = (DW+10)'(p) * (DW+10)'(K100);
		return t[DW+7:8];
	endfunction

	function automatic logic [DW-1:0] mag_fix(input logic [7:0] p, input logic [DW-1:0] q);
		logic [DW+9:0] lhs;
		logic [DW+9:0] qp;
		logic [DW+9:0] rhs;
		lhs = (DW+10)'(p) << FRAC_BITS;
		qp = (DW+10)'(q) + (DW+10)'(1);
		rhs = (qp << 6) + (qp << 5) + (qp << 2);
		return (lhs >= rhs) ? q + DW'(1) : q;
	endfunction

	function automatic logic [7:0] to_chan(input logic [CW-1:0] x);
		logic [CW+7:0] t;
		logic [CW+7-FRAC_BITS:0] c;
		t = ((CW+8)'(x) << 8) - (CW+8)'(x);
		c = t[CW+7:FRAC_BITS];
		return (c > (CW+8-FRAC_BITS)'(255)) ? 8'hFF : c[7:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/hsl_color_lightener_unit.sv =====
// hsl color lightener
// input channel: color_in with color_in_valid / color_in_stall, red 7:0,
// green 15:8, blue 23:16. a request is taken when valid is high and stall low.
// output channel: color_out with color_out_valid / color_out_stall, same packing.
// config: cfg_valid / cfg_ready with lighten_percent, a signed lightness
// offset in percent; cfg_ready is always high. write it only while idle.
// throughput: one request per clock while the output does not stall. the
// three restoring dividers (saturation and hue in parallel, then the chroma
// ratio) take one quotient bit per stage.
// a stall on the output freezes the whole pipeline; color_in_stall follows
// it in the same cycle, so nothing is dropped or repeated.
// reset clears all valid bits and loads an offset of 13 percent.
`timescale 1ns / 1ps
`default_nettype none

module hsl_color_lightener_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              color_in_valid,
	output logic                   color_in_stall,
	input  wire logic [23:0]       color_in,
	output logic                   color_out_valid,
	input  wire logic              color_out_stall,
	output logic      [23:0]       color_out,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic signed [7:0] lighten_percent
);
	import hslcl_pkg::*;

	logic en;
	logic [LAT-1:0] vld_q;
	logic signed [7:0] lighten_q;
	logic [7:0] pabs;
	logic [DW-1:0] mag_est_q;
	logic [DW-1:0] mag_q;
	logic neg_off_q;

	assign en = !(vld_q[LAT-1] && color_out_stall);
	assign color_in_stall = !en;
	assign color_out_valid = vld_q[LAT-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			lighten_q <= LIGHTEN_RST;
		end else begin
			if (cfg_valid)
				lighten_q <= lighten_percent;
			if (en)
				vld_q <= {vld_q[LAT-2:0], color_in_valid};
		end
	end

	// offset magnitude |p| * ONE / 100
	assign pabs = lighten_q[7] ? 8'(-lighten_q) : lighten_q;

	always_ff @(posedge clk) begin
		mag_est_q <= mag_est(pabs);
		mag_q <= mag_fix(pabs, mag_est_q);
		neg_off_q <= lighten_q[7];
	end

	// s1, s2: channels to fixed point
	logic [7:0] cr_s1, cg_s1, cb_s1;
	logic [XW-1:0] qr_s1, qg_s1, qb_s1;
	logic [XW-1:0] r_s2, g_s2, b_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s1 <= color_in[7:0];
			cg_s1 <= color_in[15:8];
			cb_s1 <= color_in[23:16];
			qr_s1 <= fx_est(color_in[7:0]);
			qg_s1 <= fx_est(color_in[15:8]);
			qb_s1 <= fx_est(color_in[23:16]);
			r_s2 <= fx_fix(cr_s1, qr_s1);
			g_s2 <= fx_fix(cg_s1, qg_s1);
			b_s2 <= fx_fix(cb_s1, qb_s1);
		end
	end

	// s3: min and max
	logic [XW-1:0] r_s3, g_s3, b_s3, mn_s3, mx_s3;
	logic [XW-1:0] mn_rg, mx_rg;

	assign mn_rg = (r_s2 < g_s2) ? r_s2 : g_s2;
	assign mx_rg = (r_s2 > g_s2) ? r_s2 : g_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3 <= r_s2;
			g_s3 <= g_s2;
			b_s3 <= b_s2;
			mn_s3 <= (b_s2 < mn_rg) ? b_s2 : mn_rg;
			mx_s3 <= (b_s2 > mx_rg) ? b_s2 : mx_rg;
		end
	end

	// s4: sum, spread, distances
	logic [DW-1:0] sum_s4;
	logic [XW-1:0] dist_s4, dr_s4, dg_s4, db_s4;
	logic rmax_s4, gmax_s4, rmin_s4, gmin_s4, bmin_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= DW'(mn_s3) + DW'(mx_s3);
			dist_s4 <= mx_s3 - mn_s3;
			dr_s4 <= mx_s3 - r_s3;
			dg_s4 <= mx_s3 - g_s3;
			db_s4 <= mx_s3 - b_s3;
			rmax_s4 <= r_s3 == mx_s3;
			gmax_s4 <= g_s3 == mx_s3;
			rmin_s4 <= r_s3 == mn_s3;
			gmin_s4 <= g_s3 == mn_s3;
			bmin_s4 <= b_s3 == mn_s3;
		end
	end

	// s5: divider operands
	logic [XW-1:0] l_s5;
	logic [DW-1:0] sat_den_s5, sat_num_s5, hue_num_s5;
	logic [2:0] base_s5;
	logic neg_s5, gray_s5;
	logic [XW-1:0] l4;
	logic [XW-1:0] hnum;
	logic [2:0] hbase;
	logic hneg;

	assign l4 = sum_s4[DW-1:1];

	always_comb begin
		priority if (rmax_s4) begin
			if (gmin_s4) begin
				hbase = HUE_B5; hneg = 1'b0; hnum = db_s4;
			end else begin
				hbase = HUE_B1; hneg = 1'b1; hnum = dg_s4;
			end
		end else if (gmax_s4) begin
			if (bmin_s4) begin
				hbase = HUE_B1; hneg = 1'b0; hnum = dr_s4;
			end else begin
				hbase = HUE_B3; hneg = 1'b1; hnum = db_s4;
			end
		end else begin
			if (rmin_s4) begin
				hbase = HUE_B3; hneg = 1'b0; hnum = dg_s4;
			end else begin
				hbase = HUE_B5; hneg = 1'b1; hnum = dr_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s5 <= l4;
			sat_den_s5 <= (l4 <= HALF) ? sum_s4 : TWO - sum_s4;
			sat_num_s5 <= DW'(dist_s4);
			hue_num_s5 <= DW'(hnum);
			base_s5 <= hbase;
			neg_s5 <= hneg;
			gray_s5 <= dist_s4 == '0;
		end
	end

	logic [XW-1:0] s_quo, h_quo;

	hslcl_div u_div_sat (
		.clk (clk),
		.en  (en),
		.num (sat_num_s5),
		.den (sat_den_s5),
		.quo (s_quo)
	);

	hslcl_div u_div_hue (
		.clk (clk),
		.en  (en),
		.num (hue_num_s5),
		.den (sat_num_s5),
		.quo (h_quo)
	);

	logic [XW-1:0] l_d [DIV_LAT];
	logic [2:0] base_d [DIV_LAT];
	logic neg_d [DIV_LAT];
	logic gray_d [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			l_d[0] <= l_s5;
			base_d[0] <= base_s5;
			neg_d[0] <= neg_s5;
			gray_d[0] <= gray_s5;
			for (int k = 1; k < DIV_LAT; k++) begin
				l_d[k] <= l_d[k-1];
				base_d[k] <= base_d[k-1];
				neg_d[k] <= neg_d[k-1];
				gray_d[k] <= gray_d[k-1];
			end
		end
	end

	// s6: hue, saturation, new lightness
	logic [HW-1:0] h_s6;
	logic [XW-1:0] s_s6, l_s6;
	logic [HW-1:0] hb;
	logic signed [DW+1:0] nl;

	assign hb = HW'(base_d[DIV_LAT-1]) << FRAC_BITS;
	assign nl = neg_off_q ? $signed((DW+2)'(l_d[DIV_LAT-1])) - $signed((DW+2)'(mag_q))
	                      : $signed((DW+2)'(l_d[DIV_LAT-1])) + $signed((DW+2)'(mag_q));

	always_ff @(posedge clk) begin
		if (en) begin
			if (gray_d[DIV_LAT-1]) begin
				h_s6 <= '0;
				s_s6 <= '0;
			end else begin
				h_s6 <= neg_d[DIV_LAT-1] ? hb - HW'(h_quo) : hb + HW'(h_quo);
				s_s6 <= s_quo;
			end
			priority if (nl < 0)
				l_s6 <= '0;
			else if (nl > $signed((DW+2)'(ONE)))
				l_s6 <= ONE;
			else
				l_s6 <= XW'(nl);
		end
	end

	// s7: product, s8: v, s9: m
	logic [XW+DW-1:0] prod_s7;
	logic [XW-1:0] l_s7, s_s7, l_s8;
	logic [HW-1:0] h_s7, h_s8, h_s9, h_s10;
	logic lo_s7;
	logic [DW-1:0] v_s8, v_s9, m_s9;
	logic [DW-1:0] ls7, lps7;
	logic [DW:0] two_l8;

	assign ls7 = DW'(prod_s7 >> FRAC_BITS);
	assign lps7 = DW'(l_s7) + DW'(s_s7);
	assign two_l8 = (DW+1)'(l_s8) << 1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s7 <= (XW+DW)'(l_s6) *
			           (XW+DW)'((l_s6 <= HALF) ? DW'(ONE) + DW'(s_s6) : DW'(s_s6));
			l_s7 <= l_s6;
			s_s7 <= s_s6;
			h_s7 <= h_s6;
			lo_s7 <= l_s6 <= HALF;
			if (lo_s7)
				v_s8 <= ls7;
			else
				v_s8 <= (lps7 > ls7) ? lps7 - ls7 : '0;
			l_s8 <= l_s7;
			h_s8 <= h_s7;
			v_s9 <= v_s8;
			m_s9 <= (two_l8 > (DW+1)'(v_s8)) ? DW'(two_l8 - (DW+1)'(v_s8)) : '0;
			h_s9 <= h_s8;
		end
	end

	// s10: chroma ratio operands
	logic [DW-1:0] dnum_s10, v_s10, m_s10;
	logic zero_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			dnum_s10 <= (v_s9 > m_s9) ? v_s9 - m_s9 : '0;
			v_s10 <= v_s9;
			m_s10 <= m_s9;
			h_s10 <= h_s9;
			zero_s10 <= v_s9 == '0;
		end
	end

	logic [XW-1:0] sv_quo;

	hslcl_div u_div_sv (
		.clk (clk),
		.en  (en),
		.num (dnum_s10),
		.den (v_s10),
		.quo (sv_quo)
	);

	logic [DW-1:0] v_d [DIV_LAT];
	logic [DW-1:0] m_d [DIV_LAT];
	logic [HW-1:0] h_d [DIV_LAT];
	logic zero_d [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			v_d[0] <= v_s10;
			m_d[0] <= m_s10;
			h_d[0] <= h_s10;
			zero_d[0] <= zero_s10;
			for (int k = 1; k < DIV_LAT; k++) begin
				v_d[k] <= v_d[k-1];
				m_d[k] <= m_d[k-1];
				h_d[k] <= h_d[k-1];
				zero_d[k] <= zero_d[k-1];
			end
		end
	end

	// s11..s14: sector mix and channel output
	logic [DW-1:0] vs_s11, v_s11, m_s11, vsf_s12, v_s12, m_s12;
	logic [FRAC_BITS-1:0] fract_s11;
	logic [2:0] ns_s11, ns_s12;
	logic zero_s11, zero_s12;
	logic [DW+XW-1:0] vsp;
	logic [DW+FRAC_BITS-1:0] vfp;
	logic [CW-1:0] ro_s13, go_s13, bo_s13;
	logic [CW-1:0] mid1, mid2, vc, mc;
	logic [23:0] color_s14;

	assign vsp = (DW+XW)'(v_d[DIV_LAT-1]) * (DW+XW)'(sv_quo);
	assign vfp = (DW+FRAC_BITS)'(vs_s11) * (DW+FRAC_BITS)'(fract_s11);
	assign vc = CW'(v_s12);
	assign mc = CW'(m_s12);
	assign mid1 = mc + CW'(vsf_s12);
	assign mid2 = (v_s12 > vsf_s12) ? CW'(v_s12 - vsf_s12) : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			vs_s11 <= DW'(vsp >> FRAC_BITS);
			fract_s11 <= h_d[DIV_LAT-1][FRAC_BITS-1:0];
			ns_s11 <= h_d[DIV_LAT-1][FRAC_BITS+2:FRAC_BITS];
			v_s11 <= v_d[DIV_LAT-1];
			m_s11 <= m_d[DIV_LAT-1];
			zero_s11 <= zero_d[DIV_LAT-1];
			vsf_s12 <= DW'(vfp >> FRAC_BITS);
			ns_s12 <= ns_s11;
			v_s12 <= v_s11;
			m_s12 <= m_s11;
			zero_s12 <= zero_s11;
			if (zero_s12) begin
				ro_s13 <= '0; go_s13 <= '0; bo_s13 <= '0;
			end else begin
				unique case (ns_s12)
					SEC1: begin ro_s13 <= mid2; go_s13 <= vc;   bo_s13 <= mc;   end
					SEC2: begin ro_s13 <= mc;   go_s13 <= vc;   bo_s13 <= mid1; end
					SEC3: begin ro_s13 <= mc;   go_s13 <= mid2; bo_s13 <= vc;   end
					SEC4: begin ro_s13 <= mid1; go_s13 <= mc;   bo_s13 <= vc;   end
					SEC5: begin ro_s13 <= vc;   go_s13 <= mc;   bo_s13 <= mid2; end
					default: begin ro_s13 <= vc; go_s13 <= mid1; bo_s13 <= mc; end
				endcase
			end
			color_s14 <= {to_chan(bo_s13), to_chan(go_s13), to_chan(ro_s13)};
		end
	end

	assign color_out = color_s14;

`ifndef NO_ASSERTIONS
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while output stalled");

	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(en && gray_d[DIV_LAT-1] === 1'b1) |=> (s_s6 == '0 && h_s6 == '0))
		else $error("gray color got hue or saturation");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(en && $past(en) && !$isunknown(l_s6)) |-> (l_s6 <= ONE))
		else $error("lightness out of range");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(en && zero_s12 === 1'b1) |=> (ro_s13 == '0 && go_s13 == '0 && bo_s13 == '0))
		else $error("zero value did not give black");
`endif

endmodule

`default_nettype wire

// ===== hdl/hslcl_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hslcl_div (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [hslcl_pkg::DW-1:0] num,
	input  wire logic [hslcl_pkg::DW-1:0] den,
	output logic      [hslcl_pkg::XW-1:0] quo
);
	import hslcl_pkg::*;

	// one quotient bit per stage, numerator never above denominator
	logic [DW-1:0] rem_s [DIV_LAT];
	logic [DW-1:0] den_s [DIV_LAT];
	logic [XW-1:0] quo_s [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			if (num >= den) begin
				rem_s[0] <= num - den;
				quo_s[0] <= XW'(1);
			end else begin
				rem_s[0] <= num;
				quo_s[0] <= '0;
			end
			den_s[0] <= den;
		end
	end

	for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
		logic [DW:0] sh;
		logic ge;
		assign sh = {rem_s[k-1], 1'b0};
		assign ge = sh >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(sh - {1'b0, den_s[k-1]}) : DW'(sh);
				den_s[k] <= den_s[k-1];
				quo_s[k] <= {quo_s[k-1][XW-2:0], ge};
			end
		end
	end

	assign quo = quo_s[DIV_LAT-1];

endmodule

`default_nettype wire
